// File: sv/hpwt_pkg.sv
// Shared types and constants for the handle pool with low-water-mark trimming.
package hpwt_pkg;

	localparam int HANDLE_W = 16;
	localparam int CMD_W    = 2;
	localparam int ACT_W    = 2;
	localparam int FREE_W   = 5;
	localparam int KEPT_W   = 5;
	localparam int INTV_W   = 16;
	localparam int CMP_W    = 6;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd3;

	localparam logic [ACT_W-1:0] ACT_RECYCLE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CREATE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DESTROY = 2'd2;

	localparam logic [1:0] REG_POOL_ENABLE    = 2'd0;
	localparam logic [1:0] REG_PRUNE_INTERVAL = 2'd1;
	localparam logic [1:0] REG_MAX_KEPT       = 2'd2;

	localparam logic [INTV_W-1:0] PRUNE_INTERVAL_RST = 16'd60;
	localparam logic [KEPT_W-1:0] MAX_KEPT_RST       = 5'd16;

	typedef struct packed {
		logic load;
		logic exec;
		logic pop;
	} hpwt_ctl_t;

	typedef struct packed {
		logic trim_go;
		logic pop_final;
	} hpwt_sts_t;

endpackage

// File: sv/hpwt_ctrl.sv
// Sequencer that steps each command through an execute phase and, when it trims, a trim phase.
module hpwt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hpwt_pkg::hpwt_sts_t sts,
	output hpwt_pkg::hpwt_ctl_t ctl,
	output logic              busy
);
	import hpwt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_TRIM = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = sts.trim_go ? ST_TRIM : ST_IDLE;
			end
			ST_TRIM: begin
				if (sts.pop_final) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign ctl.load = (state_q == ST_IDLE) && start;
	assign ctl.exec = (state_q == ST_EXEC);
	assign ctl.pop  = (state_q == ST_TRIM);
	assign busy     = (state_q != ST_IDLE);

endmodule

// File: sv/hpwt_datapath.sv
// Handle stacks, depth and mark counters, tick counter and result registers.
module hpwt_datapath #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hpwt_pkg::hpwt_ctl_t               ctl,
	output hpwt_pkg::hpwt_sts_t               sts,
	input  logic [hpwt_pkg::CMD_W-1:0]        cmd,
	input  logic                              manual_kind,
	input  logic [hpwt_pkg::HANDLE_W-1:0]     handle,
	input  logic                              pool_enable,
	input  logic [hpwt_pkg::INTV_W-1:0]       prune_interval,
	input  logic [hpwt_pkg::KEPT_W-1:0]       max_kept,
	output logic                              valid,
	output logic [hpwt_pkg::ACT_W-1:0]        action,
	output logic [hpwt_pkg::HANDLE_W-1:0]     out_handle,
	output logic                              out_kind,
	output logic                              last,
	output logic [hpwt_pkg::FREE_W-1:0]       free_auto,
	output logic [hpwt_pkg::FREE_W-1:0]       free_manual
);
	import hpwt_pkg::*;

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int MEM_N = 2 ** (AW + 1);

	logic [HANDLE_W-1:0] mem_q [0:MEM_N-1];
	logic [HANDLE_W-1:0] rd_q;

	logic [CMD_W-1:0]    cmd_q;
	logic                kind_q;
	logic [HANDLE_W-1:0] handle_q;

	logic [DW-1:0]       dep_a_q, dep_m_q, low_a_q, low_m_q, rem_a_q, rem_m_q;
	logic [INTV_W-1:0]   ticks_q;
	logic                pool_q;

	logic                res_valid_q, res_kind_q, res_last_q, res_mem_q;
	logic [ACT_W-1:0]    res_act_q;
	logic [HANDLE_W-1:0] res_h_q;

	logic [DW-1:0]       dep_sel, low_sel, dep_dec, cnt_a, cnt_m, na, nm, pop_dep;
	logic                hit, store, trim_hit, is_trim, pop_man, rd_en, wr_en;
	logic [INTV_W-1:0]   tick_cnt;
	logic [AW:0]         rd_addr, wr_addr;

	always_comb begin
		dep_sel  = kind_q ? dep_m_q : dep_a_q;
		low_sel  = kind_q ? low_m_q : low_a_q;
		dep_dec  = dep_sel - DW'(1);
		hit      = pool_q && (dep_sel != '0);
		store    = pool_q && (CMP_W'(dep_sel) < CMP_W'(max_kept))
			&& (dep_sel < DW'(STACK_DEPTH));
		tick_cnt = ticks_q + INTV_W'(1);
		trim_hit = !pool_enable || (tick_cnt >= prune_interval);
		is_trim  = (cmd_q == CMD_FLUSH) || ((cmd_q == CMD_TICK) && trim_hit);
		cnt_a    = ((cmd_q == CMD_TICK) && pool_enable) ? low_a_q : dep_a_q;
		cnt_m    = ((cmd_q == CMD_TICK) && pool_enable) ? low_m_q : dep_m_q;
		na       = (cnt_a < dep_a_q) ? cnt_a : dep_a_q;
		nm       = (cnt_m < dep_m_q) ? cnt_m : dep_m_q;
		pop_man  = (rem_a_q == '0);
		pop_dep  = pop_man ? dep_m_q : dep_a_q;

		sts.trim_go   = is_trim && ((na != '0) || (nm != '0));
		sts.pop_final = pop_man ? (rem_m_q == DW'(1))
			: ((rem_a_q == DW'(1)) && (rem_m_q == '0));

		rd_en   = (ctl.exec && (cmd_q == CMD_ACQUIRE) && hit) || ctl.pop;
		rd_addr = ctl.pop ? {pop_man, AW'(pop_dep - DW'(1))} : {kind_q, AW'(dep_dec)};
		wr_en   = ctl.exec && (cmd_q == CMD_RELEASE) && (handle_q != '0) && store;
		wr_addr = {kind_q, AW'(dep_sel)};
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= handle_q;
		if (rd_en) rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dep_a_q     <= '0;
			dep_m_q     <= '0;
			low_a_q     <= '0;
			low_m_q     <= '0;
			rem_a_q     <= '0;
			rem_m_q     <= '0;
			ticks_q     <= '0;
			pool_q      <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (ctl.exec) begin
				unique case (cmd_q)
					CMD_ACQUIRE: begin
						res_valid_q <= 1'b1;
						if (hit) begin
							if (kind_q) dep_m_q <= dep_dec;
							else dep_a_q <= dep_dec;
							if (dep_dec < low_sel) begin
								if (kind_q) low_m_q <= dep_dec;
								else low_a_q <= dep_dec;
							end
						end else if (pool_q) begin
							if (kind_q) low_m_q <= '0;
							else low_a_q <= '0;
						end
					end
					CMD_RELEASE: begin
						if (handle_q != '0) begin
							if (store) begin
								if (kind_q) dep_m_q <= dep_sel + DW'(1);
								else dep_a_q <= dep_sel + DW'(1);
							end else begin
								res_valid_q <= 1'b1;
							end
						end
					end
					CMD_TICK: begin
						pool_q  <= pool_enable;
						ticks_q <= trim_hit ? '0 : tick_cnt;
						if (trim_hit) begin
							low_a_q <= dep_a_q - na;
							low_m_q <= dep_m_q - nm;
							rem_a_q <= na;
							rem_m_q <= nm;
						end
					end
					CMD_FLUSH: begin
						low_a_q <= dep_a_q - na;
						low_m_q <= dep_m_q - nm;
						rem_a_q <= na;
						rem_m_q <= nm;
					end
				endcase
			end else if (ctl.pop) begin
				res_valid_q <= 1'b1;
				if (pop_man) begin
					dep_m_q <= dep_m_q - DW'(1);
					rem_m_q <= rem_m_q - DW'(1);
				end else begin
					dep_a_q <= dep_a_q - DW'(1);
					rem_a_q <= rem_a_q - DW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= cmd;
			kind_q   <= manual_kind;
			handle_q <= handle;
		end
		if (ctl.exec) begin
			res_kind_q <= kind_q;
			res_last_q <= 1'b1;
			res_mem_q  <= (cmd_q == CMD_ACQUIRE) && hit;
			res_h_q    <= (cmd_q == CMD_ACQUIRE) ? '0 : handle_q;
			if (cmd_q == CMD_ACQUIRE) res_act_q <= hit ? ACT_RECYCLE : ACT_CREATE;
			else res_act_q <= ACT_DESTROY;
		end else if (ctl.pop) begin
			res_kind_q <= pop_man;
			res_last_q <= sts.pop_final;
			res_mem_q  <= 1'b1;
			res_h_q    <= '0;
			res_act_q  <= ACT_DESTROY;
		end
	end

	assign valid       = res_valid_q;
	assign action      = res_act_q;
	assign out_handle  = res_mem_q ? rd_q : res_h_q;
	assign out_kind    = res_kind_q;
	assign last        = res_last_q;
	assign free_auto   = FREE_W'(dep_a_q);
	assign free_manual = FREE_W'(dep_m_q);

endmodule

// File: sv/handle_pool_watermark_trim_core.sv
// Top level of the handle pool: configuration registers, sequencer and datapath.
//
// Commands enter on cmd, manual_kind and handle; a beat is taken at a clock edge
// where start is high and busy is low. Results leave on action, out_handle,
// out_kind, last, free_auto and free_manual, each beat marked by valid for one
// cycle; last flags the final result of a command. The receiver cannot stall.
// An acquire, or a release of a nonzero handle that is not kept, passes through
// the execute state and the result registers; other releases give no beat. The
// next command is taken while the result of the last is shown. A tick that trims,
// or a flush, passes through the execute state and then gives one destroy beat
// per cycle, auto stack then manual, a rate set by the memory's single read port.
// The APB port holds pool_enable at 0x0, prune_interval at 0x4 and max_kept at
// 0x8; writes must only be made while the block is idle. Reset empties both stacks,
// clears the marks and tick counter and loads the register defaults; there is no
// clearing pass, so commands are taken in the first cycle after reset.
module handle_pool_watermark_trim_core #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [hpwt_pkg::CMD_W-1:0]          cmd,
	input  logic                                manual_kind,
	input  logic [hpwt_pkg::HANDLE_W-1:0]       handle,
	output logic                                valid,
	output logic [hpwt_pkg::ACT_W-1:0]          action,
	output logic [hpwt_pkg::HANDLE_W-1:0]       out_handle,
	output logic                                out_kind,
	output logic                                last,
	output logic [hpwt_pkg::FREE_W-1:0]         free_auto,
	output logic [hpwt_pkg::FREE_W-1:0]         free_manual,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [hpwt_pkg::APB_AW-1:0]         paddr,
	input  logic [hpwt_pkg::APB_DW-1:0]         pwdata,
	output logic [hpwt_pkg::APB_DW-1:0]         prdata,
	output logic                                pready
);
	import hpwt_pkg::*;

	logic                pool_enable_q;
	logic [INTV_W-1:0]   prune_interval_q;
	logic [KEPT_W-1:0]   max_kept_q;
	logic                wr_strobe;
	logic [1:0]          reg_idx;
	hpwt_ctl_t           ctl;
	hpwt_sts_t           sts;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign wr_strobe = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_enable_q    <= 1'b1;
			prune_interval_q <= PRUNE_INTERVAL_RST;
			max_kept_q       <= MAX_KEPT_RST;
		end else if (wr_strobe) begin
			if (reg_idx == REG_POOL_ENABLE) pool_enable_q <= pwdata[0];
			if (reg_idx == REG_PRUNE_INTERVAL) prune_interval_q <= pwdata[INTV_W-1:0];
			if (reg_idx == REG_MAX_KEPT) max_kept_q <= pwdata[KEPT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_POOL_ENABLE) prdata = APB_DW'(pool_enable_q);
		else if (reg_idx == REG_PRUNE_INTERVAL) prdata = APB_DW'(prune_interval_q);
		else if (reg_idx == REG_MAX_KEPT) prdata = APB_DW'(max_kept_q);
	end

	hpwt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	hpwt_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.cmd            (cmd),
		.manual_kind    (manual_kind),
		.handle         (handle),
		.pool_enable    (pool_enable_q),
		.prune_interval (prune_interval_q),
		.max_kept       (max_kept_q),
		.valid          (valid),
		.action         (action),
		.out_handle     (out_handle),
		.out_kind       (out_kind),
		.last           (last),
		.free_auto      (free_auto),
		.free_manual    (free_manual)
	);

endmodule

// File: sv/hpwt_checker.sv
// Port-level checks on the handle pool, bound to the top level.
module hpwt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            valid,
	input logic                            last,
	input logic [hpwt_pkg::ACT_W-1:0]      action,
	input logic [hpwt_pkg::HANDLE_W-1:0]   out_handle
);
	import hpwt_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted command did not make the block busy.");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !valid)
		else $error("Result beat appeared without a command in progress.");

	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> valid)
		else $error("Destroy burst broke off before its last beat.");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |=> !valid)
		else $error("Result beat followed the last beat of a command.");

	a_create_null: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (action == ACT_CREATE) |-> (out_handle == '0))
		else $error("Create beat carried a nonzero handle.");

endmodule

bind handle_pool_watermark_trim_core hpwt_checker u_hpwt_checker (.*);
